// ===== sv/sha256_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash values, command/status types.
// No dependencies.
package sha256_pkg;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	typedef logic [31:0] word_t;

	// controller -> datapath
	typedef struct packed {
		logic       hash_init;   // load initial hash values, clear length
		logic       buf_wr;      // write buf_data at buf_addr
		logic [5:0] buf_addr;
		logic [7:0] buf_data;
		logic       len_add_blk; // message_bits += 512
		logic       len_add_tail;// message_bits += fill*8
		logic [5:0] tail_bytes;
		logic       cmp_start;   // load round vars from hash words
		logic       cmp_round;   // run one round
		logic [5:0] round_idx;
		logic       cmp_fold;    // hash += round vars
		logic [2:0] out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [63:0] message_bits;
	} dp_stat_t;

	function automatic word_t round_k(input logic [5:0] t);
		case (t)
			6'd0: return 32'h428a2f98; 6'd1: return 32'h71374491; 6'd2: return 32'hb5c0fbcf;
			6'd3: return 32'he9b5dba5; 6'd4: return 32'h3956c25b; 6'd5: return 32'h59f111f1;
			6'd6: return 32'h923f82a4; 6'd7: return 32'hab1c5ed5; 6'd8: return 32'hd807aa98;
			6'd9: return 32'h12835b01; 6'd10: return 32'h243185be; 6'd11: return 32'h550c7dc3;
			6'd12: return 32'h72be5d74; 6'd13: return 32'h80deb1fe; 6'd14: return 32'h9bdc06a7;
			6'd15: return 32'hc19bf174; 6'd16: return 32'he49b69c1; 6'd17: return 32'hefbe4786;
			6'd18: return 32'h0fc19dc6; 6'd19: return 32'h240ca1cc; 6'd20: return 32'h2de92c6f;
			6'd21: return 32'h4a7484aa; 6'd22: return 32'h5cb0a9dc; 6'd23: return 32'h76f988da;
			6'd24: return 32'h983e5152; 6'd25: return 32'ha831c66d; 6'd26: return 32'hb00327c8;
			6'd27: return 32'hbf597fc7; 6'd28: return 32'hc6e00bf3; 6'd29: return 32'hd5a79147;
			6'd30: return 32'h06ca6351; 6'd31: return 32'h14292967; 6'd32: return 32'h27b70a85;
			6'd33: return 32'h2e1b2138; 6'd34: return 32'h4d2c6dfc; 6'd35: return 32'h53380d13;
			6'd36: return 32'h650a7354; 6'd37: return 32'h766a0abb; 6'd38: return 32'h81c2c92e;
			6'd39: return 32'h92722c85; 6'd40: return 32'ha2bfe8a1; 6'd41: return 32'ha81a664b;
			6'd42: return 32'hc24b8b70; 6'd43: return 32'hc76c51a3; 6'd44: return 32'hd192e819;
			6'd45: return 32'hd6990624; 6'd46: return 32'hf40e3585; 6'd47: return 32'h106aa070;
			6'd48: return 32'h19a4c116; 6'd49: return 32'h1e376c08; 6'd50: return 32'h2748774c;
			6'd51: return 32'h34b0bcb5; 6'd52: return 32'h391c0cb3; 6'd53: return 32'h4ed8aa4a;
			6'd54: return 32'h5b9cca4f; 6'd55: return 32'h682e6ff3; 6'd56: return 32'h748f82ee;
			6'd57: return 32'h78a5636f; 6'd58: return 32'h84c87814; 6'd59: return 32'h8cc70208;
			6'd60: return 32'h90befffa; 6'd61: return 32'ha4506ceb; 6'd62: return 32'hbef9a3f7;
			default: return 32'hc67178f2;
		endcase
	endfunction

	function automatic word_t init_h(input logic [2:0] i);
		case (i)
			3'd0: return 32'h6a09e667; 3'd1: return 32'hbb67ae85;
			3'd2: return 32'h3c6ef372; 3'd3: return 32'ha54ff53a;
			3'd4: return 32'h510e527f; 3'd5: return 32'h9b05688c;
			3'd6: return 32'h1f83d9ab; default: return 32'h5be0cd19;
		endcase
	endfunction

endpackage

// ===== sv/sha256_stream_if.sv =====
// Valid/ready stream interface with a parameterized payload type.
// Depends on nothing.
interface sha256_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/sha256_dp.sv =====
// SHA-256 datapath: block buffer memory, hash words, round variables, schedule window.
// Depends on sha256_pkg.
module sha256_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::dp_cmd_t   cmd,
	output sha256_pkg::dp_stat_t  stat,
	output sha256_pkg::word_t     digest_word
);
	sha256_pkg::word_t hash_q [8];
	sha256_pkg::word_t rv_q [8];
	sha256_pkg::word_t win_q [16];
	logic [31:0] buf_q [16];     // block buffer, one 32-bit word per row
	logic [63:0] bits_q;
	logic [31:0] buf_rd_q;       // row used by the next round

	sha256_pkg::word_t w, s0, s1, t1, t2, e, a, w15, w2;

	// memory write: byte lane within a row; registered read runs one row ahead
	always_ff @(posedge clk) begin
		if (cmd.buf_wr) begin
			case (cmd.buf_addr[1:0])
				2'd0: buf_q[cmd.buf_addr[5:2]][31:24] <= cmd.buf_data;
				2'd1: buf_q[cmd.buf_addr[5:2]][23:16] <= cmd.buf_data;
				2'd2: buf_q[cmd.buf_addr[5:2]][15:8] <= cmd.buf_data;
				default: buf_q[cmd.buf_addr[5:2]][7:0] <= cmd.buf_data;
			endcase
		end
		buf_rd_q <= buf_q[cmd.cmp_round ? 4'(cmd.round_idx[3:0] + 4'd1) : 4'd0];
	end

	always_comb begin
		w15 = win_q[4'(cmd.round_idx[3:0] + 4'd1)];
		w2 = win_q[4'(cmd.round_idx[3:0] + 4'd14)];
		s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		if (cmd.round_idx < 6'd16)
			w = buf_rd_q;
		else
			w = win_q[cmd.round_idx[3:0]] + s0 + win_q[4'(cmd.round_idx[3:0] + 4'd9)] + s1;
		e = rv_q[4];
		a = rv_q[0];
		t1 = rv_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]}) +
			((e & rv_q[5]) ^ (~e & rv_q[6])) + sha256_pkg::round_k(cmd.round_idx) + w;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) +
			((a & rv_q[1]) ^ (a & rv_q[2]) ^ (rv_q[1] & rv_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp_start) begin
			for (int i = 0; i < 8; i++) rv_q[i] <= hash_q[i];
		end else if (cmd.cmp_round) begin
			win_q[cmd.round_idx[3:0]] <= w;
			for (int i = 1; i < 8; i++) rv_q[i] <= rv_q[i-1];
			rv_q[4] <= rv_q[3] + t1;
			rv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_h(3'(i));
			bits_q <= '0;
		end else begin
			if (cmd.hash_init) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_h(3'(i));
				bits_q <= '0;
			end else begin
				if (cmd.cmp_fold)
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + rv_q[i];
				if (cmd.len_add_blk)
					bits_q <= bits_q + sha256_pkg::BLOCK_BITS;
				else if (cmd.len_add_tail)
					bits_q <= bits_q + {55'd0, cmd.tail_bytes, 3'd0};
			end
		end
	end

	assign stat.message_bits = bits_q;
	assign digest_word = hash_q[cmd.out_sel];
endmodule

// ===== sv/sha256_ctrl.sv =====
// SHA-256 controller: byte intake, padding sequencer, round counter, digest output.
// Depends on sha256_pkg.
module sha256_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_func,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_index,
	output sha256_pkg::dp_cmd_t   cmd,
	input  sha256_pkg::dp_stat_t  stat
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_START = 7'b0000010,
		S_ROUND = 7'b0000100,
		S_FOLD  = 7'b0001000,
		S_PAD   = 7'b0010000,
		S_LEN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [5:0] fill_q, round_q;
	logic [2:0] idx_q;
	logic       fin_q;   // compressing a final block
	logic       lenblk_q; // the current final compression carries the length

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_index = idx_q;

	always_comb begin
		cmd = '0;
		cmd.round_idx = round_q;
		cmd.out_sel = idx_q;
		cmd.tail_bytes = fill_q;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.buf_wr = 1'b1;
					cmd.buf_addr = fill_q;
					if (!in_func) begin
						cmd.buf_data = in_byte;
						if (fill_q == 6'd63) state_d = S_START;
					end else begin
						// pad mark at the fill position; in the last byte before the length: no zero fill
						cmd.buf_data = sha256_pkg::PAD_MARK;
						cmd.len_add_tail = 1'b1;
						state_d = (fill_q == 6'd63) ? S_START :
							(fill_q == 6'd55) ? S_LEN : S_PAD;
					end
				end
			end
			S_PAD: begin
				// zero fill up to the length field, or to block end if no room
				cmd.buf_wr = 1'b1;
				cmd.buf_addr = fill_q;
				cmd.buf_data = 8'd0;
				if (!lenblk_q && fill_q == 6'd63) state_d = S_START;
				else if (lenblk_q && fill_q == 6'd55) state_d = S_LEN;
			end
			S_LEN: begin
				cmd.buf_wr = 1'b1;
				cmd.buf_addr = fill_q;
				cmd.buf_data = stat.message_bits[8*(7-fill_q[2:0]) +: 8];
				if (fill_q == 6'd63) state_d = S_START;
			end
			S_START: begin
				cmd.cmp_start = 1'b1;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.cmp_round = 1'b1;
				if (round_q == 6'd63) state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.cmp_fold = 1'b1;
				if (!fin_q) begin
					cmd.len_add_blk = 1'b1;
					state_d = S_IDLE;
				end else if (lenblk_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_PAD;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (idx_q == 3'd7) begin
						cmd.hash_init = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			round_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					fill_q <= fill_q + 6'd1;
					fin_q <= in_func;
					lenblk_q <= in_func && (fill_q < sha256_pkg::LEN_POS);
				end
				S_PAD, S_LEN: begin
					fill_q <= fill_q + 6'd1;
				end
				S_START: round_q <= '0;
				S_ROUND: round_q <= round_q + 6'd1;
				S_FOLD: if (fin_q && !lenblk_q) lenblk_q <= 1'b1;
				S_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						fill_q <= '0;
						fin_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== sv/sha256_byte_stream_hasher_top.sv =====
// Top level of the SHA-256 byte-stream hasher.
// Depends on sha256_pkg, sha256_stream_if, sha256_ctrl, sha256_dp.
//
// Feed the message one byte per transfer with func = 0; a transfer with
// func = 1 closes the message, pads it and returns the digest as eight
// 32-bit big-endian words, word_index 0..7, last_word on the eighth, after
// which the hash restarts for a new message. Bytes are taken one per cycle
// while input ready is high; the 64th byte of a block starts the
// one-round-per-cycle compression (load, 64 rounds, fold), during which input
// ready is low. Finish writes the remaining pad and length bytes, one per
// cycle, runs one compression, or two when the length spills into a second
// block, then makes eight output transfers. The block holds one item at a
// time: input ready is low from the finish transfer until the last digest
// word is taken.
module sha256_byte_stream_hasher_top (
	input logic clk,
	input logic arst_n,
	sha256_stream_if.sink   in_ch,
	sha256_stream_if.source out_ch
);
	sha256_pkg::dp_cmd_t  cmd;
	sha256_pkg::dp_stat_t stat;
	logic [2:0] idx;

	sha256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_func(in_ch.payload.func), .in_byte(in_ch.payload.data_byte),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_index(idx), .cmd(cmd), .stat(stat)
	);

	sha256_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.digest_word(out_ch.payload.digest_word)
	);

	assign out_ch.payload.word_index = idx;
	assign out_ch.payload.last_word = (idx == 3'd7);
endmodule

// ===== sv/sha256_checker.sv =====
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_top.
module sha256_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] widx,
	input logic       wlast
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (wlast == (widx == 3'd7)))
		else $error("last_word mismatch");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input open while digest pending");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && widx != 3'd7) |=> (out_valid && widx == $past(widx) + 3'd1))
		else $error("digest word order");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !$past(out_valid)) |-> widx == 3'd0)
		else $error("digest not starting at word 0");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> !out_valid || !in_ready)
		else $error("input stall state");
endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.widx(out_ch.payload.word_index), .wlast(out_ch.payload.last_word)
);

// ===== dv/sha256_byte_stream_hasher_top_tb.sv =====
// Self-checking testbench for sha256_byte_stream_hasher_top: feeds byte messages,
// predicts each digest with an in-bench SHA-256 and checks every word.
// Depends on sha256_pkg, sha256_stream_if and the hasher RTL.
module sha256_byte_stream_hasher_top_tb;

	typedef enum logic {FN_ABSORB = 1'b0, FN_FINISH = 1'b1} func_e;

	// Payload layouts of the two channels, field names as the block uses them
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] HINIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	logic clk;
	logic arst_n;

	sha256_stream_if #(.payload_t(byte_item_t))   in_ch();
	sha256_stream_if #(.payload_t(digest_item_t)) out_ch();

	sha256_byte_stream_hasher_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Digest predictor: its own hash state, byte buffer and length
	// ---------------------------------------------------------------
	logic [31:0]  hv [8];
	logic [7:0]   blk [64];
	int           fill;
	logic [63:0]  msg_bits;
	digest_item_t digest_q[$];   // digest words still owed by the block
	int           errors;
	bit           no_idle;       // stretch with no gaps or stalls on either side

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic fold_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int t = 0; t < 64; t++) begin
			if (t < 16)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			else
				w[t] = w[t-16] + w[t-7]
					+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
					+ (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ KTAB[t] + w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			hv[i] = HINIT[i];
		fill = 0;
		msg_bits = '0;
	endtask

	// Called once per accepted input transfer
	task automatic predict_digest(byte_item_t it);
		digest_item_t d;
		if (it.func == FN_ABSORB) begin
			blk[fill] = it.data_byte;
			fill++;
			if (fill == 64) begin
				fold_block();
				msg_bits += 64'd512;
				fill = 0;
			end
			return;
		end
		msg_bits += 64'(fill) * 8;
		blk[fill] = sha256_pkg::PAD_MARK;
		fill++;
		// no room for the length: pad out and fold an extra block
		if (fill > 56) begin
			while (fill < 64)
				blk[fill++] = 8'h00;
			fold_block();
			fill = 0;
		end
		while (fill < 56)
			blk[fill++] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk[56+i] = msg_bits[63-8*i -: 8];
		fold_block();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hv[i];
			d.word_index = 3'(i);
			d.last_word = (i == 7);
			digest_q = {digest_q, d};
		end
		restart_hash();
	endtask

	// ---------------------------------------------------------------
	// Input side: one transfer per call, random gap before it
	// ---------------------------------------------------------------
	task automatic send_item(func_e fn, logic [7:0] data);
		int gap;
		byte_item_t it;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		it.func = fn;
		it.data_byte = data;
		in_ch.payload = it;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_digest(it);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_item(FN_ABSORB, 8'($urandom_range(0, 255)));
		send_item(FN_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// Output side: random stall before each word, then check it
	// ---------------------------------------------------------------
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		digest_item_t exp_d;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest transfer %h", $time, out_ch.payload);
				errors++;
			end else begin
				exp_d = digest_q.pop_front();
				if (out_ch.payload.digest_word !== exp_d.digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time,
						exp_d.digest_word, out_ch.payload.digest_word);
					errors++;
				end
				if (out_ch.payload.word_index !== exp_d.word_index) begin
					$display("%0t: word_index expected %0d actual %0d", $time,
						exp_d.word_index, out_ch.payload.word_index);
					errors++;
				end
				if (out_ch.payload.last_word !== exp_d.last_word) begin
					$display("%0t: last_word expected %0b actual %0b", $time,
						exp_d.last_word, out_ch.payload.last_word);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles in a row with no transfer on either channel
	int idle_cycles;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Directed table: fn, byte, and for finish rows with a well known
	// digest the expected first word (empty string, "abc")
	// ---------------------------------------------------------------
	typedef struct {
		func_e       fn;
		logic [7:0]  data;
		bit          has_w0;
		logic [31:0] w0;
	} dir_row_t;

	localparam int N_DIR = 12;
	dir_row_t dir_tab [N_DIR] = '{
		'{FN_FINISH, 8'h00, 1, 32'he3b0c442},   // empty message
		'{FN_FINISH, 8'hff, 1, 32'he3b0c442},   // empty again, byte ignored
		'{FN_ABSORB, 8'h61, 0, 0},
		'{FN_ABSORB, 8'h62, 0, 0},
		'{FN_ABSORB, 8'h63, 0, 0},
		'{FN_FINISH, 8'h00, 1, 32'hba7816bf},   // "abc"
		'{FN_ABSORB, 8'h00, 0, 0},
		'{FN_FINISH, 8'h00, 0, 0},
		'{FN_ABSORB, 8'hff, 0, 0},
		'{FN_FINISH, 8'h00, 0, 0},
		'{FN_ABSORB, 8'h80, 0, 0},
		'{FN_FINISH, 8'hff, 0, 0}
	};

	// message lengths around the pad and block boundaries
	localparam int N_EDGE = 8;
	int edge_lens [N_EDGE] = '{55, 56, 57, 63, 64, 65, 0, 1};

	initial begin
		int sent, len;
		errors = 0;
		no_idle = 0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		restart_hash();
		for (int i = 0; i < 64; i++)
			blk[i] = 8'h00;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			send_item(dir_tab[r].fn, dir_tab[r].data);
			if (dir_tab[r].has_w0 && digest_q[digest_q.size()-8].digest_word !== dir_tab[r].w0) begin
				$display("%0t: known digest expected %h actual %h", $time, dir_tab[r].w0,
					digest_q[digest_q.size()-8].digest_word);
				errors++;
			end
		end

		// boundary lengths first, then mostly short random messages
		sent = N_DIR;
		for (int i = 0; i < N_EDGE; i++) begin
			no_idle = (i % 4 == 3);
			send_message(edge_lens[i]);
			sent += edge_lens[i] + 1;
		end
		while (sent < 460) begin
			no_idle = ($urandom_range(0, 5) == 0);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 12);
			send_message(len);
			sent += len + 1;
		end
		@(negedge clk);
		in_ch.valid = 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
